// ----- rtl/core/dtcd_pkg.sv -----
// ----------------------------------------------------------------------------
// dtcd_pkg
// Shared types and constants for the dirty tile change detector.
// ----------------------------------------------------------------------------
`default_nettype none

package dtcd_pkg;

	localparam int MAX_TILES = 4096;
	localparam int TILE_SIDE = 16;

	localparam int FUNC_W   = 2;
	localparam int DATA_W   = 24;
	localparam int TIDX_W   = 12;
	localparam int OFF_W    = 8;
	localparam int TCFG_W   = 13;
	localparam int COUNT_W  = 13;

	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH   = 2'd0,
		FUNC_READ   = 2'd1,
		FUNC_FORGET = 2'd2
	} func_t;

	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	typedef struct packed {
		logic              is_read;
		logic              cmp_en;
		logic              no_prev;
		logic              tile_end;
		logic              frame_end;
		logic [TIDX_W-1:0] tile_idx;
		logic [DATA_W-1:0] pixel;
		logic [DATA_W-1:0] data;
	} q_entry_t;

	typedef struct packed {
		logic valid;
		logic full;
		logic afull;
	} q_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/dtcd_front.sv -----
// ----------------------------------------------------------------------------
// dtcd_front
// Accepts and decodes items, walks the tile position, owns the frame store.
// ----------------------------------------------------------------------------
`default_nettype none

module dtcd_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [dtcd_pkg::TCFG_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [dtcd_pkg::FUNC_W-1:0]   func,
	input  wire logic [dtcd_pkg::DATA_W-1:0]   pixel,
	input  wire logic                          pad,
	input  wire logic [dtcd_pkg::TIDX_W-1:0]   read_tile,
	input  wire logic [dtcd_pkg::OFF_W-1:0]    read_offset,
	input  wire dtcd_pkg::q_stat_t             q_stat,
	output logic                               q_push,
	output dtcd_pkg::q_entry_t                 q_in
);

	localparam int MAX_TILES   = dtcd_pkg::MAX_TILES;
	localparam int TILE_SIDE   = dtcd_pkg::TILE_SIDE;
	localparam int TILE_PIXELS = TILE_SIDE * TILE_SIDE;
	localparam int STORE_DEPTH = MAX_TILES * TILE_PIXELS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int TILE_W      = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
	localparam int PC_W        = $clog2(TILE_PIXELS);
	localparam int CNT_W       = $clog2(MAX_TILES + 1);

	logic [dtcd_pkg::DATA_W-1:0] store_mem [STORE_DEPTH];

	logic [TILE_W-1:0]           tile_q;
	logic [PC_W-1:0]             pix_q;
	logic                        have_prev_q;
	logic [CNT_W-1:0]            limit_q;

	logic                        valid_s1;
	logic                        in_range_s1;
	dtcd_pkg::q_entry_t          ent_s1;
	logic [dtcd_pkg::DATA_W-1:0] rdata_s1;

	logic                        acc;
	logic                        is_push;
	logic                        is_read;
	logic                        is_forget;
	logic                        tile_end;
	logic                        done;
	logic                        in_range;
	logic                        mem_we;
	logic [ADDR_W-1:0]           addr;
	logic [dtcd_pkg::DATA_W-1:0] wdata;
	dtcd_pkg::q_entry_t          ent;

	assign in_ready = !q_stat.afull;
	assign acc      = in_valid && in_ready;

	always_comb begin
		is_push   = 1'b0;
		is_read   = 1'b0;
		is_forget = 1'b0;
		unique case (func)
			dtcd_pkg::FUNC_PUSH:   is_push   = 1'b1;
			dtcd_pkg::FUNC_READ:   is_read   = 1'b1;
			dtcd_pkg::FUNC_FORGET: is_forget = 1'b1;
			default: ;
		endcase
	end

	assign tile_end = (pix_q == PC_W'(TILE_PIXELS - 1));
	assign done     = (CNT_W'(tile_q) + CNT_W'(1)) >= limit_q;
	assign in_range = (32'(read_tile) < MAX_TILES) && (32'(read_offset) < TILE_PIXELS);
	assign mem_we   = acc && is_push;
	assign wdata    = pad ? '0 : pixel;

	always_comb begin
		if (is_push) begin
			addr = ADDR_W'(tile_q) * ADDR_W'(TILE_PIXELS) + ADDR_W'(pix_q);
		end else begin
			addr = ADDR_W'(read_tile) * ADDR_W'(TILE_PIXELS) + ADDR_W'(read_offset);
		end
	end

	always_comb begin
		ent           = '0;
		ent.is_read   = is_read;
		ent.cmp_en    = have_prev_q && !pad;
		ent.no_prev   = !have_prev_q;
		ent.tile_end  = is_push && tile_end;
		ent.frame_end = is_push && tile_end && done;
		ent.tile_idx  = dtcd_pkg::TIDX_W'(tile_q);
		ent.pixel     = pixel;
	end

	// single port, read-first: a push sees the old pixel
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[addr] <= wdata;
		end
		rdata_s1 <= store_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ent_s1      <= ent;
			in_range_s1 <= in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			tile_q      <= '0;
			pix_q       <= '0;
			have_prev_q <= 1'b0;
			limit_q     <= CNT_W'(1);
		end else begin
			valid_s1 <= acc && (is_push || is_read);
			if (cfg_we) begin
				if (cfg_data == '0) begin
					limit_q <= CNT_W'(1);
				end else if (32'(cfg_data) > MAX_TILES) begin
					limit_q <= CNT_W'(MAX_TILES);
				end else begin
					limit_q <= CNT_W'(cfg_data);
				end
			end
			if (acc && is_forget) begin
				have_prev_q <= 1'b0;
			end
			if (acc && is_push) begin
				if (tile_end) begin
					pix_q <= '0;
					if (done) begin
						tile_q      <= '0;
						have_prev_q <= 1'b1;
					end else begin
						tile_q <= tile_q + TILE_W'(1);
					end
				end else begin
					pix_q <= pix_q + PC_W'(1);
				end
			end
		end
	end

	assign q_push = valid_s1;

	always_comb begin
		q_in      = ent_s1;
		q_in.data = (ent_s1.is_read && !in_range_s1) ? '0 : rdata_s1;
	end

endmodule

`default_nettype wire

// ----- rtl/core/dtcd_queue.sv -----
// ----------------------------------------------------------------------------
// dtcd_queue
// Short FIFO between front and back; almost-full gives the front its credit.
// ----------------------------------------------------------------------------
`default_nettype none

module dtcd_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire dtcd_pkg::q_entry_t in_entry,
	input  wire logic               pop,
	output dtcd_pkg::q_entry_t      head,
	output dtcd_pkg::q_stat_t       stat
);

	dtcd_pkg::q_entry_t                slot_q [dtcd_pkg::QDEPTH];
	logic [dtcd_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [dtcd_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [dtcd_pkg::QCNT_W-1:0]       count_q;
	logic                              do_push;
	logic                              do_pop;

	assign do_push = push && !stat.full;
	assign do_pop  = pop && stat.valid;

	assign head       = slot_q[rd_ptr_q];
	assign stat.valid = (count_q != '0);
	assign stat.full  = (count_q == dtcd_pkg::QCNT_W'(dtcd_pkg::QDEPTH));
	assign stat.afull = (count_q >= dtcd_pkg::QCNT_W'(dtcd_pkg::QDEPTH - 1));

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= in_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + dtcd_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + dtcd_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + dtcd_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - dtcd_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/dtcd_back.sv -----
// ----------------------------------------------------------------------------
// dtcd_back
// Pixel compare, tile verdict, changed tally and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtcd_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire dtcd_pkg::q_entry_t            head,
	input  wire dtcd_pkg::q_stat_t             q_stat,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               kind,
	output logic [dtcd_pkg::TIDX_W-1:0]        tile_index,
	output logic                               changed,
	output logic                               frame_done,
	output logic [dtcd_pkg::COUNT_W-1:0]       changed_count,
	output logic [dtcd_pkg::DATA_W-1:0]        read_pixel
);

	localparam int CNT_W = $clog2(dtcd_pkg::MAX_TILES + 1);

	logic                          out_valid_q;
	logic                          kind_q;
	logic [dtcd_pkg::TIDX_W-1:0]   tile_index_q;
	logic                          changed_q;
	logic                          frame_done_q;
	logic [dtcd_pkg::COUNT_W-1:0]  changed_count_q;
	logic [dtcd_pkg::DATA_W-1:0]   read_pixel_q;

	logic                          differs_q;
	logic [CNT_W-1:0]              tally_q;

	logic                          out_free;
	logic                          emits;
	logic                          diff;
	logic                          acc_diff;
	logic                          chg;
	logic [CNT_W-1:0]              tally_nxt;

	assign out_free  = !out_valid_q || out_ready;
	assign emits     = head.is_read || head.tile_end;
	assign pop       = q_stat.valid && (!emits || out_free);
	assign diff      = head.cmp_en && (head.data != head.pixel);
	assign acc_diff  = differs_q || diff;
	assign chg       = acc_diff || head.no_prev;
	assign tally_nxt = tally_q + CNT_W'(chg);

	always_ff @(posedge clk) begin
		if (pop && emits) begin
			if (head.is_read) begin
				kind_q          <= dtcd_pkg::KIND_READ;
				tile_index_q    <= '0;
				changed_q       <= 1'b0;
				frame_done_q    <= 1'b0;
				changed_count_q <= '0;
				read_pixel_q    <= head.data;
			end else begin
				kind_q          <= dtcd_pkg::KIND_REPORT;
				tile_index_q    <= head.tile_idx;
				changed_q       <= chg;
				frame_done_q    <= head.frame_end;
				changed_count_q <= dtcd_pkg::COUNT_W'(tally_nxt);
				read_pixel_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			differs_q   <= 1'b0;
			tally_q     <= '0;
		end else begin
			if (pop && emits) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop && !head.is_read) begin
				if (head.tile_end) begin
					differs_q <= 1'b0;
					tally_q   <= head.frame_end ? '0 : tally_nxt;
				end else begin
					differs_q <= acc_diff;
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign tile_index    = tile_index_q;
	assign changed       = changed_q;
	assign frame_done    = frame_done_q;
	assign changed_count = changed_count_q;
	assign read_pixel    = read_pixel_q;

endmodule

`default_nettype wire

// ----- rtl/core/dirty_tile_change_detector_top.sv -----
// ----------------------------------------------------------------------------
// dirty_tile_change_detector_top
// Per-tile frame difference against a stored previous frame.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one transfer per item; func selects
// pixel push, stored-pixel read or forget. Pixels come in tile order,
// each tile row by row. Output channel (out_valid/out_ready): a tile
// report after the last pixel of each tile, or a read reply.
// cfg_we/cfg_data set the tiles per frame; write only while idle.
// Throughput: one item per cycle while in_ready is high, set by the single
// read-first port of the frame store (one access per item). A result
// passes the store read register, which loads at the transfer of the item
// that causes it, then the queue, then the output register.
// The front keeps taking items while a result waits; a stalled receiver
// backs items up into the four-entry queue, and in_ready drops once three
// are queued, the last slot taking the item still in the store read stage.
// Reset: tile position and tally cleared, no previous frame, so the first
// frame reports every tile changed. The frame store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module dirty_tile_change_detector_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [dtcd_pkg::TCFG_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [dtcd_pkg::FUNC_W-1:0]   func,
	input  wire logic [dtcd_pkg::DATA_W-1:0]   pixel,
	input  wire logic                          pad,
	input  wire logic [dtcd_pkg::TIDX_W-1:0]   read_tile,
	input  wire logic [dtcd_pkg::OFF_W-1:0]    read_offset,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               kind,
	output logic [dtcd_pkg::TIDX_W-1:0]        tile_index,
	output logic                               changed,
	output logic                               frame_done,
	output logic [dtcd_pkg::COUNT_W-1:0]       changed_count,
	output logic [dtcd_pkg::DATA_W-1:0]        read_pixel
);

	dtcd_pkg::q_stat_t  q_stat;
	dtcd_pkg::q_entry_t q_in;
	dtcd_pkg::q_entry_t q_head;
	logic               q_push;
	logic               q_pop;

	dtcd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.pixel       (pixel),
		.pad         (pad),
		.read_tile   (read_tile),
		.read_offset (read_offset),
		.q_stat      (q_stat),
		.q_push      (q_push),
		.q_in        (q_in)
	);

	dtcd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.in_entry (q_in),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	dtcd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.q_stat        (q_stat),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.tile_index    (tile_index),
		.changed       (changed),
		.frame_done    (frame_done),
		.changed_count (changed_count),
		.read_pixel    (read_pixel)
	);

	// credit scheme must never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_stat.valid)
		else $error("queue underflow");

	a_read_reply_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == dtcd_pkg::KIND_READ) |->
		(tile_index == '0 && !changed && !frame_done && changed_count == '0))
		else $error("read reply carries report fields");

	a_report_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == dtcd_pkg::KIND_REPORT) |-> (read_pixel == '0))
		else $error("tile report carries pixel data");

endmodule

`default_nettype wire

// ----- bench/tb_dirty_tile_change_detector_top.sv -----
// ----------------------------------------------------------------------------
// tb_dirty_tile_change_detector_top
// Self-checking bench for the dirty tile change detector. Pixel, read and
// forget items go in over a valid/ready channel with random gaps, and the
// receiver stalls at random. A tracker keeps its own frame store and tile
// position, predicts every tile report and read reply, and compares each
// output transfer field by field. Phases step the tile count through small,
// zero, oversized and mid-frame lowered values. Reads only touch entries
// already written, and a tile not yet stored is never compared.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dirty_tile_change_detector_top;

	localparam int MAX_TILES    = dtcd_pkg::MAX_TILES;
	localparam int TILE_SIDE    = dtcd_pkg::TILE_SIDE;
	localparam int TILE_PIXELS  = TILE_SIDE * TILE_SIDE;
	localparam int STORE_DEPTH  = MAX_TILES * TILE_PIXELS;
	localparam int ITEMS        = 1450;
	localparam int TAIL_ITEMS   = 480;
	localparam int DRAIN_CYCLES = 10;
	localparam int LIMIT        = 3000000;

	localparam logic [dtcd_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

	typedef struct packed {
		logic                         kind;
		logic [dtcd_pkg::TIDX_W-1:0]  tile_index;
		logic                         changed;
		logic                         frame_done;
		logic [dtcd_pkg::COUNT_W-1:0] changed_count;
		logic [dtcd_pkg::DATA_W-1:0]  read_pixel;
	} detect_out_t;

	class tile_change_tracker;
		bit [dtcd_pkg::DATA_W-1:0] frame_mem [STORE_DEPTH];
		int unsigned written_top;
		bit          prev_valid;
		bit          tile_dirty;
		int unsigned tile_pos;
		int unsigned pix_pos;
		int unsigned tally;
		int unsigned tiles_cfg;
		int unsigned reports;
		int unsigned errors;
		detect_out_t awaited [$];

		function new();
			tiles_cfg = 1;
		endfunction

		function void set_tiles(logic [dtcd_pkg::TCFG_W-1:0] v);
			tiles_cfg = 32'(v);
		endfunction

		function int unsigned frame_tiles();
			if (tiles_cfg == 0) return 1;
			if (tiles_cfg > MAX_TILES) return MAX_TILES;
			return tiles_cfg;
		endfunction

		function logic [dtcd_pkg::DATA_W-1:0] next_stored();
			return frame_mem[tile_pos * TILE_PIXELS + pix_pos];
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function void take_item(logic [dtcd_pkg::FUNC_W-1:0] f,
				logic [dtcd_pkg::DATA_W-1:0] px, logic pd,
				logic [dtcd_pkg::TIDX_W-1:0] rt, logic [dtcd_pkg::OFF_W-1:0] ro);
			detect_out_t r;
			int unsigned addr;
			bit done_now;
			r = '0;
			if (f == dtcd_pkg::FUNC_FORGET) begin
				prev_valid = 1'b0;
				return;
			end
			if (f == dtcd_pkg::FUNC_READ) begin
				r.kind = dtcd_pkg::KIND_READ;
				if (rt < MAX_TILES && ro < TILE_PIXELS)
					r.read_pixel = frame_mem[rt * TILE_PIXELS + ro];
				awaited.push_back(r);
				return;
			end
			if (f != dtcd_pkg::FUNC_PUSH) return;

			if (tile_pos >= MAX_TILES) tile_pos = 0;
			if (pix_pos >= TILE_PIXELS) pix_pos = 0;
			addr = tile_pos * TILE_PIXELS + pix_pos;
			if (pd) begin
				frame_mem[addr] = '0;
			end else begin
				if (prev_valid && frame_mem[addr] != px) tile_dirty = 1'b1;
				frame_mem[addr] = px;
			end
			if (addr >= written_top) written_top = addr + 1;

			pix_pos++;
			if (pix_pos < TILE_PIXELS) return;

			r.kind = dtcd_pkg::KIND_REPORT;
			r.tile_index = tile_pos[dtcd_pkg::TIDX_W-1:0];
			r.changed = tile_dirty || !prev_valid;
			if (r.changed) tally++;
			done_now = (tile_pos + 1) >= frame_tiles();
			r.frame_done = done_now;
			r.changed_count = tally[dtcd_pkg::COUNT_W-1:0];
			awaited.push_back(r);
			reports++;

			pix_pos = 0;
			tile_dirty = 1'b0;
			if (done_now) begin
				tile_pos = 0;
				tally = 0;
				prev_valid = 1'b1;
			end else begin
				tile_pos++;
			end
		endfunction

		function void field_check(string name, logic [31:0] want, logic [31:0] seen);
			if (want !== seen) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
				errors++;
			end
		endfunction

		function void match_result(detect_out_t got);
			detect_out_t want;
			if (awaited.size() == 0) begin
				$error("unexpected result: kind %0d tile_index %0d read_pixel 0x%0h",
					got.kind, got.tile_index, got.read_pixel);
				errors++;
				return;
			end
			want = awaited.pop_front();
			field_check("kind", 32'(want.kind), 32'(got.kind));
			field_check("tile_index", 32'(want.tile_index), 32'(got.tile_index));
			field_check("changed", 32'(want.changed), 32'(got.changed));
			field_check("frame_done", 32'(want.frame_done), 32'(got.frame_done));
			field_check("changed_count", 32'(want.changed_count), 32'(got.changed_count));
			field_check("read_pixel", 32'(want.read_pixel), 32'(got.read_pixel));
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [dtcd_pkg::TCFG_W-1:0]   cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [dtcd_pkg::FUNC_W-1:0]   func;
	logic [dtcd_pkg::DATA_W-1:0]   pixel;
	logic                          pad;
	logic [dtcd_pkg::TIDX_W-1:0]   read_tile;
	logic [dtcd_pkg::OFF_W-1:0]    read_offset;
	logic                          out_valid;
	logic                          out_ready;
	logic                          kind;
	logic [dtcd_pkg::TIDX_W-1:0]   tile_index;
	logic                          changed;
	logic                          frame_done;
	logic [dtcd_pkg::COUNT_W-1:0]  changed_count;
	logic [dtcd_pkg::DATA_W-1:0]   read_pixel;

	bit                  tx_gaps_on;
	bit                  rx_steady;
	int unsigned         items_sent;
	tile_change_tracker  tracker;

	always #5 clk = ~clk;

	dirty_tile_change_detector_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.pixel(pixel),
		.pad(pad),
		.read_tile(read_tile),
		.read_offset(read_offset),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.tile_index(tile_index),
		.changed(changed),
		.frame_done(frame_done),
		.changed_count(changed_count),
		.read_pixel(read_pixel)
	);

	// mostly short, now and then long
	function automatic int unsigned idle_span();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	initial begin : rx_side
		int unsigned stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_steady) begin
				out_ready <= 1'b1;
				stall_left = 0;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 99) < 20) stall_left = idle_span();
			end
		end
	end

	always @(posedge clk) begin : watch
		detect_out_t got;
		if (arst_n && out_valid && out_ready) begin
			got.kind = kind;
			got.tile_index = tile_index;
			got.changed = changed;
			got.frame_done = frame_done;
			got.changed_count = changed_count;
			got.read_pixel = read_pixel;
			tracker.match_result(got);
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("dirty_tile_change_detector_top: mismatch");
		$finish;
	end

	task automatic send(input logic [dtcd_pkg::FUNC_W-1:0] f,
			input logic [dtcd_pkg::DATA_W-1:0] px, input logic pd,
			input logic [dtcd_pkg::TIDX_W-1:0] rt, input logic [dtcd_pkg::OFF_W-1:0] ro);
		int unsigned gap;
		gap = 0;
		if (tx_gaps_on && $urandom_range(0, 99) >= 60) gap = idle_span();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		func <= f;
		pixel <= px;
		pad <= pd;
		read_tile <= rt;
		read_offset <= ro;
		do @(posedge clk); while (in_ready !== 1'b1);
		tracker.take_item(f, px, pd, rt, ro);
		if (f != FUNC_SPARE) items_sent++;
	endtask

	task automatic read_back();
		int unsigned a;
		if (tracker.written_top == 0) return;
		a = $urandom_range(0, tracker.written_top - 1);
		send(dtcd_pkg::FUNC_READ, dtcd_pkg::DATA_W'($urandom), 1'($urandom_range(0, 1)),
			dtcd_pkg::TIDX_W'(a / TILE_PIXELS), dtcd_pkg::OFF_W'(a % TILE_PIXELS));
	endtask

	// rest of the current tile: copy of the stored tile, one bit flipped, or fresh
	task automatic push_tile(input bit extras);
		int unsigned style;
		int unsigned pad_row;
		int unsigned flip_at;
		int unsigned o;
		logic [dtcd_pkg::DATA_W-1:0] px;
		logic pd;
		style = $urandom_range(0, 99);
		pad_row = ($urandom_range(0, 99) < 75) ? TILE_SIDE : $urandom_range(0, TILE_SIDE - 1);
		flip_at = $urandom_range(0, TILE_PIXELS - 1);
		// a tile not yet stored has nothing to compare against
		if (tracker.prev_valid &&
				(tracker.tile_pos * TILE_PIXELS + TILE_PIXELS > tracker.written_top))
			send(dtcd_pkg::FUNC_FORGET, dtcd_pkg::DATA_W'($urandom), 1'($urandom_range(0, 1)),
				dtcd_pkg::TIDX_W'($urandom), dtcd_pkg::OFF_W'($urandom));
		for (o = tracker.pix_pos; o < TILE_PIXELS; o++) begin
			if (extras) begin
				if ($urandom_range(0, 99) < 10) read_back();
				if ($urandom_range(0, 999) < 2)
					send(dtcd_pkg::FUNC_FORGET, dtcd_pkg::DATA_W'($urandom),
						1'($urandom_range(0, 1)), dtcd_pkg::TIDX_W'($urandom),
						dtcd_pkg::OFF_W'($urandom));
				if ($urandom_range(0, 99) < 1)
					send(FUNC_SPARE, dtcd_pkg::DATA_W'($urandom), 1'($urandom_range(0, 1)),
						dtcd_pkg::TIDX_W'($urandom), dtcd_pkg::OFF_W'($urandom));
			end
			pd = (o / TILE_SIDE) >= pad_row;
			px = tracker.next_stored();
			if (pd || style >= 60) begin
				case ($urandom_range(0, 9))
					0: px = '0;
					1: px = '1;
					default: px = dtcd_pkg::DATA_W'($urandom);
				endcase
			end else if (style >= 35 && o == flip_at) begin
				px = px ^ (24'd1 << $urandom_range(0, dtcd_pkg::DATA_W - 1));
			end
			send(dtcd_pkg::FUNC_PUSH, px, pd, dtcd_pkg::TIDX_W'($urandom),
				dtcd_pkg::OFF_W'($urandom));
		end
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_tiles(input logic [dtcd_pkg::TCFG_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.set_tiles(v);
	endtask

	initial begin : stimulus
		logic [dtcd_pkg::TCFG_W-1:0] tiles;
		int unsigned r;
		int unsigned n;
		tracker = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		func = '0;
		pixel = '0;
		pad = 1'b0;
		read_tile = '0;
		read_offset = '0;
		tx_gaps_on = 1'b0;
		rx_steady = 1'b1;
		items_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// tile count still at its reset value
		send(FUNC_SPARE, '1, 1'b1, '1, '1);
		send(dtcd_pkg::FUNC_FORGET, '0, 1'b0, '0, '0);
		send(dtcd_pkg::FUNC_PUSH, '0, 1'b0, '1, '1);
		send(dtcd_pkg::FUNC_PUSH, '1, 1'b0, '0, '0);
		send(dtcd_pkg::FUNC_PUSH, '1, 1'b1, '0, '0);
		send(dtcd_pkg::FUNC_PUSH, '0, 1'b1, '1, '1);
		for (n = 0; n < 4; n++)
			send(dtcd_pkg::FUNC_READ, '1, 1'b1, '0, dtcd_pkg::OFF_W'(n));
		push_tile(1'b0);
		send(dtcd_pkg::FUNC_READ, '0, 1'b0, '0, '1);

		while (items_sent < ITEMS - TAIL_ITEMS) begin
			settle();
			r = $urandom_range(0, 99);
			if (r < 12) tiles = '0;
			else if (r < 22) tiles = '1;
			else if (r < 28) tiles = dtcd_pkg::TCFG_W'(MAX_TILES);
			else if (r < 33) tiles = dtcd_pkg::TCFG_W'($urandom);
			else tiles = dtcd_pkg::TCFG_W'($urandom_range(1, 4));
			write_tiles(tiles);
			tx_gaps_on = $urandom_range(0, 3) != 0;
			rx_steady = $urandom_range(0, 3) == 0;
			push_tile(1'b1);
		end

		// tile count lowered to one: the next finished tile ends the frame
		settle();
		write_tiles(dtcd_pkg::TCFG_W'(1));
		tx_gaps_on = 1'b1;
		rx_steady = 1'b0;
		push_tile(1'b1);
		send(dtcd_pkg::FUNC_READ, '0, 1'b0,
			dtcd_pkg::TIDX_W'((tracker.written_top - 1) / TILE_PIXELS),
			dtcd_pkg::OFF_W'((tracker.written_top - 1) % TILE_PIXELS));
		repeat (60) read_back();
		settle();

		if (tracker.errors == 0)
			$display("dirty_tile_change_detector_top: match");
		else
			$display("dirty_tile_change_detector_top: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

// ----- dirty_tile_change_detector_top.f -----
rtl/core/dtcd_pkg.sv
rtl/core/dtcd_front.sv
rtl/core/dtcd_queue.sv
rtl/core/dtcd_back.sv
rtl/core/dirty_tile_change_detector_top.sv
bench/tb_dirty_tile_change_detector_top.sv
